/* rtl/sdclk_pkg.sv */
// Shared types, register indexes and field constants for the SD host clock divider.
package sdclk_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } sdclk_state_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_BASE_CLOCK_HZ    = 2'd0;
  localparam cfg_index_t CFG_CLOCK_MULTIPLIER = 2'd1;
  localparam cfg_index_t CFG_SPEC_V3          = 2'd2;

  localparam logic [31:0] BASE_CLOCK_RESET = 32'd200000000;
  localparam logic [7:0]  MULT_RESET       = 8'd0;
  localparam logic        SPEC_V3_RESET    = 1'b1;

  localparam int          DATA_W   = 32;
  localparam int          CODE_W   = 10;
  localparam int          WORD_W   = 16;
  localparam logic [9:0]  CODE_MAX = 10'd1023;

  localparam int PROG_BIT   = 5;
  localparam int INT_EN_BIT = 0;

  // Clamp a wide divider code to the ten-bit field.
  function automatic logic [CODE_W-1:0] sat_code(input logic [33:0] v);
    logic [CODE_W-1:0] r;
    if (v > 34'(CODE_MAX)) r = CODE_MAX;
    else                   r = v[CODE_W-1:0];
    return r;
  endfunction

  // Place the code into the clock control register layout.
  function automatic logic [WORD_W-1:0] pack_word(input logic [CODE_W-1:0] code,
                                                  input logic prog);
    logic [WORD_W-1:0] w;
    w             = '0;
    w[15:8]       = code[7:0];
    w[7:6]        = code[9:8];
    w[PROG_BIT]   = prog;
    w[INT_EN_BIT] = 1'b1;
    return w;
  endfunction

endpackage

/* rtl/sd_host_clock_divider_top.sv */
// SD host clock divider: request in Hz to clock control word via a shared bit-serial divider.
//
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// input    | start / busy        | in_requested_hz[31:0]
// result   | out_valid (strobe)  | out_clock_control_word[15:0], out_divider_code[9:0]
// config   | cfg_we              | cfg_index[1:0], cfg_wdata[31:0]
//
// A transaction runs in steps: the load on the accepted start, the restoring divider (one
// quotient bit per cycle for base / (request + 1)), a finish step that selects the divisor
// and registers the packed word, then the result strobe.
// busy is high from the accepted start until the strobe; start is taken again in the
// strobe cycle. The receiver cannot stall; each result shows for exactly one cycle.
// Synchronous active-low reset restores the register defaults and idles the sequencer.
module sd_host_clock_divider_top #(
  parameter int PROG_DIV_LIMIT = 1024,
  parameter int MAX_DIV_V3     = 2046,
  parameter int MAX_DIV_V2     = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 in_requested_hz,
  output logic                        out_valid,
  output logic [15:0]                 out_clock_control_word,
  output logic [9:0]                  out_divider_code,
  input  logic                        cfg_we,
  input  sdclk_pkg::cfg_index_t       cfg_index,
  input  logic [31:0]                 cfg_wdata
);
  import sdclk_pkg::*;

  localparam int          V2_STEPS = $clog2(MAX_DIV_V2);
  localparam logic [33:0] EVEN_CAP = 34'(((MAX_DIV_V3 + 1) / 2) * 2);
  localparam logic [33:0] PROG_CAP = 34'(PROG_DIV_LIMIT + 1);
  localparam logic [33:0] V3_MAX   = 34'(MAX_DIV_V3);

  // Configuration registers
  logic [31:0] base_clock_r;
  logic [7:0]  mult_r;
  logic        spec_v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_clock_r <= BASE_CLOCK_RESET;
      mult_r       <= MULT_RESET;
      spec_v3_r    <= SPEC_V3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_CLOCK_HZ:    base_clock_r <= cfg_wdata;
        CFG_CLOCK_MULTIPLIER: mult_r       <= cfg_wdata[7:0];
        CFG_SPEC_V3:          spec_v3_r    <= cfg_wdata[0];
        default:              ;
      endcase
    end
  end

  // Sequencer
  sdclk_state_t state_r, state_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         load, div_step, finish;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 5'd0) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    load     = 1'b0;
    div_step = 1'b0;
    finish   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        load = start;
      end
      ST_DIV:    div_step = 1'b1;
      ST_FINISH: finish   = 1'b1;
      default:   busy     = 1'b1;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (load)          cnt_nxt = 5'd31;
    else if (div_step) cnt_nxt = cnt_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Restoring divider: quot_r starts as the dividend and fills with quotient bits
  logic [31:0] quot_r;
  logic [32:0] rem_r;
  logic [32:0] divisor_r;
  logic        req_zero_r;
  logic [33:0] trial;
  logic [33:0] diff;

  assign trial = {rem_r, quot_r[31]};
  assign diff  = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (load) begin
      quot_r     <= base_clock_r;
      rem_r      <= '0;
      divisor_r  <= {1'b0, in_requested_hz} + 33'd1;
      req_zero_r <= (in_requested_hz == '0);
    end else if (div_step) begin
      if (!diff[33]) begin
        rem_r  <= diff[32:0];
        quot_r <= {quot_r[30:0], 1'b1};
      end else begin
        rem_r  <= trial[32:0];
        quot_r <= {quot_r[30:0], 1'b0};
      end
    end
  end

  // Divisor selection from dmin = quotient + 1
  logic [33:0]         dmin;
  logic [33:0]         prog_d;
  logic [33:0]         even_d;
  logic [33:0]         v2_d;
  logic [CODE_W-1:0]   code;
  logic                prog_mode;

  assign dmin = {2'b00, quot_r} + 34'd1;

  always_comb begin
    prog_mode = 1'b0;
    prog_d    = (dmin > PROG_CAP) ? PROG_CAP : dmin;
    even_d    = (dmin + 34'd1) & ~34'd1;
    if (even_d >= V3_MAX) even_d = EVEN_CAP;
    // smallest power of two that reaches dmin, capped at the top step
    v2_d = 34'd1 << V2_STEPS;
    for (int k = V2_STEPS; k >= 0; k--) begin
      if (dmin <= (34'd1 << k)) v2_d = 34'd1 << k;
    end
    if (spec_v3_r && (mult_r != '0)) begin
      prog_mode = 1'b1;
      code      = sat_code(prog_d - 34'd1);
    end else if (spec_v3_r) begin
      if (dmin <= 34'd1) code = '0;
      else               code = sat_code(even_d >> 1);
    end else begin
      code = sat_code(v2_d >> 1);
    end
  end

  // Result register
  logic              out_valid_r;
  logic [WORD_W-1:0] word_r;
  logic [CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= finish;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (req_zero_r) begin
        word_r <= '0;
        code_r <= '0;
      end else begin
        word_r <= pack_word(code, prog_mode);
        code_r <= code;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_clock_control_word = word_r;
  assign out_divider_code       = code_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FINISH))
    else $error("result strobe without a finish cycle");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted start did not raise busy");

  a_word_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_clock_control_word[15:8] == out_divider_code[7:0] &&
                   out_clock_control_word[7:6] == out_divider_code[9:8]))
    else $error("packed word disagrees with divider code");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> $past(state_r == ST_DIV && cnt_r == 5'd0))
    else $error("divider left early");
`endif

endmodule
